// File: rtl/core/lcg_pkg.sv
// package for the linear chirp generator: register indexes, queue constants,
// queue status type and the elaboration-time sine table entry function
// no dependencies
package lcg_pkg;

  localparam int CfgDataBits = 32;
  localparam int CfgIdxBits  = 1;

  localparam logic [CfgIdxBits-1:0] RegStartIncrement = 1'b0;
  localparam logic [CfgIdxBits-1:0] RegIncrementStep  = 1'b1;

  localparam int QueueDepth = 4;

  localparam longint HalfPiQ30 = 64'sd1686629713;
  localparam longint OneQ30    = 64'sd1073741824;

  typedef struct packed {
    logic full;
    logic not_empty;
  } queue_status_t;

  // quarter-wave entry k of a 2^tbl_bits table, amplitude 2^amp_bits,
  // odd taylor series in q2.30 up to the x^17 term
  function automatic longint sine_entry(int tbl_bits, int amp_bits, int k);
    longint x;
    longint x2;
    longint term;
    longint sum;
    longint amp;
    longint v;
    x    = (HalfPiQ30 * longint'(k)) >>> tbl_bits;
    x2   = (x * x) >>> 30;
    term = x;
    sum  = x;
    amp  = 64'sd1 <<< amp_bits;
    for (int n = 1; n <= 8; n++) begin
      term = (term * x2) >>> 30;
      case (n)
        1: term = term / 6;
        2: term = term / 20;
        3: term = term / 42;
        4: term = term / 72;
        5: term = term / 110;
        6: term = term / 156;
        7: term = term / 210;
        default: term = term / 272;
      endcase
      if ((n % 2) == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    if (sum < 0) sum = 0;
    if (sum > OneQ30) sum = OneQ30;
    v = (sum * amp + (OneQ30 >>> 1)) >>> 30;
    if (v > amp) v = amp;
    return v;
  endfunction

endpackage

// File: rtl/core/lcg_queue.sv
// short register queue between the phase front end and the sine back end
// depends on lcg_pkg for the status type
module lcg_queue #(
  parameter int WIDTH = 28,
  parameter int DEPTH = 4
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push_i,
  input  logic [WIDTH-1:0]          push_data_i,
  input  logic                      pop_i,
  output logic [WIDTH-1:0]          head_o,
  output lcg_pkg::queue_status_t    status_o
);

  localparam int PtrBits = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntBits = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]   entry_q [DEPTH];
  logic [PtrBits-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrBits-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntBits-1:0] count_q, count_d;
  logic               do_push, do_pop;

  assign status_o.full      = (count_q == CntBits'(DEPTH));
  assign status_o.not_empty = (count_q != '0);
  assign do_push = push_i && !status_o.full;
  assign do_pop  = pop_i && status_o.not_empty;
  assign head_o  = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrBits'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrBits'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && status_o.full && !pop_i |=> $stable(count_q))
    else $error("queue count moved on a push into a full queue");
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntBits'(DEPTH))
    else $error("queue count beyond depth");
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_pop |-> count_q != '0)
    else $error("pop from empty queue");

endmodule

// File: rtl/core/lcg_front.sv
// front end: configuration registers, request intake, phase and increment
// accumulators; pushes quadrant, table index and sample into the queue
// depends on lcg_pkg
module lcg_front #(
  parameter int PHASE_BITS      = 32,
  parameter int SINE_TABLE_BITS = 10,
  parameter int SAMPLE_BITS     = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [lcg_pkg::CfgIdxBits-1:0]        cfg_idx_i,
  input  logic [lcg_pkg::CfgDataBits-1:0]       cfg_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic                                  restart_i,
  input  logic [SAMPLE_BITS-1:0]                sample_i,
  output logic                                  push_o,
  output logic [SINE_TABLE_BITS+SAMPLE_BITS+1:0] push_data_o,
  input  lcg_pkg::queue_status_t                q_status_i
);

  localparam int TopBits = SINE_TABLE_BITS + 2;

  logic [lcg_pkg::CfgDataBits-1:0] start_inc_q;
  logic [lcg_pkg::CfgDataBits-1:0] inc_step_q;
  logic [PHASE_BITS-1:0] phase_acc_q, phase_acc_d;
  logic [PHASE_BITS-1:0] phase_inc_q, phase_inc_d;
  logic [PHASE_BITS-1:0] phase_use, inc_use, step_ext;
  logic                  accept;

  assign in_ready_o = !q_status_i.full;
  assign accept     = in_valid_i && in_ready_o;
  assign step_ext   = PHASE_BITS'(signed'(inc_step_q));

  always_comb begin
    phase_use   = restart_i ? '0 : phase_acc_q;
    inc_use     = restart_i ? PHASE_BITS'(start_inc_q) : phase_inc_q;
    phase_acc_d = phase_acc_q;
    phase_inc_d = phase_inc_q;
    if (accept) begin
      phase_acc_d = phase_use + inc_use;
      phase_inc_d = inc_use + step_ext;
    end
  end

  assign push_o      = accept;
  assign push_data_o = {phase_use[PHASE_BITS-1 -: TopBits], sample_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_inc_q <= '0;
      inc_step_q  <= '0;
      phase_acc_q <= '0;
      phase_inc_q <= '0;
    end else begin
      phase_acc_q <= phase_acc_d;
      phase_inc_q <= phase_inc_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          lcg_pkg::RegStartIncrement: start_inc_q <= cfg_data_i;
          lcg_pkg::RegIncrementStep:  inc_step_q  <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  a_restart_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && restart_i && !cfg_we_i |=> phase_acc_q == PHASE_BITS'($past(start_inc_q)))
    else $error("phase after restart is not the start increment");
  a_restart_inc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && restart_i |=>
      phase_inc_q == PHASE_BITS'($past(start_inc_q)) + $past(step_ext))
    else $error("increment after restart wrong");

endmodule

// File: rtl/core/lcg_sine_rom.sv
// quarter-wave sine table, contents built at elaboration, registered read
// depends on lcg_pkg::sine_entry
module lcg_sine_rom #(
  parameter int SINE_TABLE_BITS = 10,
  parameter int SAMPLE_BITS     = 16
) (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [SINE_TABLE_BITS:0]   addr_i,
  output logic [SAMPLE_BITS-2:0]     data_o
);

  localparam int Depth = (1 << SINE_TABLE_BITS) + 1;

  logic [SAMPLE_BITS-2:0] rom_table [Depth];
  logic [SAMPLE_BITS-2:0] data_q;

  for (genvar k = 0; k < Depth; k++) begin : g_entry
    assign rom_table[k] = (SAMPLE_BITS-1)'(
      lcg_pkg::sine_entry(SINE_TABLE_BITS, SAMPLE_BITS - 2, k));
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= rom_table[addr_i];
    end
  end

  assign data_o = data_q;

endmodule

// File: rtl/core/lcg_back.sv
// back end: pops the queue, table lookup with quadrant folding,
// signed add with saturation into the output register
// depends on lcg_pkg and lcg_sine_rom
module lcg_back #(
  parameter int SINE_TABLE_BITS = 10,
  parameter int SAMPLE_BITS     = 16
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic [SINE_TABLE_BITS+SAMPLE_BITS+1:0] head_i,
  input  lcg_pkg::queue_status_t                 q_status_i,
  output logic                                   pop_o,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic [SAMPLE_BITS-1:0]                 sample_o
);

  localparam int TB = SINE_TABLE_BITS;
  localparam int SB = SAMPLE_BITS;
  localparam logic [TB:0] TableN = (TB+1)'(1) << TB;

  logic [1:0]      quad;
  logic [TB-1:0]   idx;
  logic [TB:0]     rom_addr;
  logic [SB-2:0]   rom_data;
  logic            advance;
  logic            v1_q, neg1_q;
  logic [SB-1:0]   sample1_q;
  logic            out_valid_q;
  logic [SB-1:0]   out_q;
  logic signed [SB:0] sum;
  logic [SB:0]     sine_ext;

  assign quad     = head_i[SB+TB+1 -: 2];
  assign idx      = head_i[SB +: TB];
  assign rom_addr = quad[0] ? TableN - {1'b0, idx} : {1'b0, idx};

  assign advance = !out_valid_q || out_ready_i;
  assign pop_o   = advance && q_status_i.not_empty;

  lcg_sine_rom #(
    .SINE_TABLE_BITS(TB),
    .SAMPLE_BITS    (SB)
  ) u_rom (
    .clk_i (clk_i),
    .en_i  (advance),
    .addr_i(rom_addr),
    .data_o(rom_data)
  );

  always_comb begin
    sine_ext = {2'b00, rom_data};
    sum = neg1_q ? signed'({sample1_q[SB-1], sample1_q}) - signed'(sine_ext)
                 : signed'({sample1_q[SB-1], sample1_q}) + signed'(sine_ext);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      v1_q        <= q_status_i.not_empty;
      out_valid_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      neg1_q    <= quad[1];
      sample1_q <= head_i[SB-1:0];
      if (sum[SB] != sum[SB-1]) begin
        out_q <= sum[SB] ? {1'b1, {(SB-1){1'b0}}} : {1'b0, {(SB-1){1'b1}}};
      end else begin
        out_q <= sum[SB-1:0];
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign sample_o    = out_q;

  a_stage_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && v1_q |=> out_valid_q)
    else $error("looked-up request lost before the output register");
  a_hold_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(v1_q) && (!v1_q || $stable(sample1_q)))
    else $error("lookup stage changed while stalled");

endmodule

// File: rtl/core/linear_chirp_generator.sv
// top level of the linear chirp generator: front end, request queue, back end
// depends on lcg_pkg, lcg_front, lcg_queue, lcg_back
//
// channel   dir  handshake                  payload
// s_axis    in   tvalid/tready              tdata: sample_in, tuser: restart
// m_axis    out  tvalid/tready              tdata: sample_out
// cfg       in   cfg_we_i                   cfg_idx_i, cfg_data_i
//
// one request per cycle while the queue is not full, set by the phase accumulator add in the front end
// a request passes the queue write, the table read register and the output register, in that order
// reset clears phase, increment, both registers and the queue
// s_axis_tready falls only when the four-entry queue fills under output stall
module linear_chirp_generator #(
  parameter int PHASE_BITS      = 32,
  parameter int SINE_TABLE_BITS = 10,
  parameter int SAMPLE_BITS     = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [lcg_pkg::CfgIdxBits-1:0]       cfg_idx_i,
  input  logic [lcg_pkg::CfgDataBits-1:0]      cfg_data_i,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]     s_axis_tdata,  // sample_in
  input  logic                                 s_axis_tuser,  // restart
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [((SAMPLE_BITS+7)/8)*8-1:0]     m_axis_tdata   // sample_out
);

  localparam int QW     = SINE_TABLE_BITS + SAMPLE_BITS + 2;
  localparam int DataW  = ((SAMPLE_BITS + 7) / 8) * 8;

  logic                   push, pop;
  logic [QW-1:0]          push_data, head;
  lcg_pkg::queue_status_t q_status;
  logic [SAMPLE_BITS-1:0] sample_out;

  lcg_front #(
    .PHASE_BITS     (PHASE_BITS),
    .SINE_TABLE_BITS(SINE_TABLE_BITS),
    .SAMPLE_BITS    (SAMPLE_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .restart_i  (s_axis_tuser),
    .sample_i   (s_axis_tdata[SAMPLE_BITS-1:0]),
    .push_o     (push),
    .push_data_o(push_data),
    .q_status_i (q_status)
  );

  lcg_queue #(
    .WIDTH(QW),
    .DEPTH(lcg_pkg::QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_data),
    .pop_i      (pop),
    .head_o     (head),
    .status_o   (q_status)
  );

  lcg_back #(
    .SINE_TABLE_BITS(SINE_TABLE_BITS),
    .SAMPLE_BITS    (SAMPLE_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head),
    .q_status_i (q_status),
    .pop_o      (pop),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .sample_o   (sample_out)
  );

  assign m_axis_tdata = DataW'(sample_out);

endmodule
